/* hdl/nal_unit_fu_fragmenter_core_assert.svh */
// ----------------------------------------------------------------------------
// nal_unit_fu_fragmenter_core_assert
// Assertion macros for the FU fragmenter. Clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef NAL_UNIT_FU_FRAGMENTER_CORE_ASSERT_SVH
`define NAL_UNIT_FU_FRAGMENTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NUFF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fragmenter assertion failed");

// Next-cycle implication, checked out of reset.
`define NUFF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fragmenter assertion failed");

`endif

/* hdl/nuff_pkg.sv */
// ----------------------------------------------------------------------------
// nuff_pkg
// Types and constants shared by the FU fragmenter front end, queue and back end.
// ----------------------------------------------------------------------------
package nuff_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int QDEPTH          = 2;

	localparam int          FILL_W          = 12;
	localparam logic [11:0] MAXSIZE         = 12'd1200;
	localparam logic        REG_CODEC_MODE  = 1'b0;
	localparam logic        REG_MAX_PAYLOAD = 1'b1;

	localparam logic [7:0] FU_A_TYPE   = 8'd28;
	localparam logic [7:0] HEVC_FU_TYP = 8'd49;
	localparam logic [7:0] H264_TYPE_M = 8'h1f;
	localparam logic [7:0] HEVC_TYPE_M = 8'h7e;
	localparam logic [7:0] H264_KEEP_M = 8'he0;
	localparam logic [7:0] HEVC_KEEP_M = 8'h81;
	localparam logic [7:0] FU_S_BIT    = 8'h80;
	localparam logic [7:0] FU_E_BIT    = 8'h40;

	// One request handed from the front end to the back end.
	typedef struct packed {
		logic       has_hdr;   // fragment opens here: header bytes precede data
		logic       hevc;
		logic [7:0] hb0;
		logic [7:0] hb1;
		logic [7:0] hb2;
		logic [7:0] data;
		logic       frag_end;
	} job_t;

endpackage

/* hdl/nal_unit_fu_fragmenter_core.sv */
// ----------------------------------------------------------------------------
// nal_unit_fu_fragmenter_core
// RTP FU fragmenter for H.264 (FU-A) and HEVC NAL units, one byte per request.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_stall     data_byte, nal_first, nal_length
//   out      source     out_valid / out_stall   out_byte, fragment_begin,
//                                               fragment_end, run_last
//   cfg      sink       cfg_we                  cfg_index, cfg_data
//
// A payload byte gives one output byte; a byte that opens a fragment gives
// three (H.264) or four (HEVC), one byte a cycle while out_stall is low.
// Input takes one byte per cycle until the two-entry request queue fills.
// Header and ignored bytes give no output. Others are queued, then registered.
// Reset clears control state; codec_mode resets to H.264, max_payload to 1200.
// in_stall rises only on a full queue; out_stall holds the output register.
// ----------------------------------------------------------------------------
`include "nal_unit_fu_fragmenter_core_assert.svh"

module nal_unit_fu_fragmenter_core
	import nuff_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        nal_first,
	input  logic [15:0] nal_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        fragment_begin,
	output logic        fragment_end,
	output logic        run_last
);

	logic        codec_mode_q;
	logic [11:0] max_payload_q;

	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q  <= 1'b0;
			max_payload_q <= MAXSIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODEC_MODE:  codec_mode_q  <= cfg_data[0];
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	nuff_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.codec_mode (codec_mode_q),
		.max_payload(max_payload_q),
		.in_valid   (in_valid),
		.data_byte  (data_byte),
		.nal_first  (nal_first),
		.nal_length (nal_length),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	nuff_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	nuff_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.fragment_begin(fragment_begin),
		.fragment_end  (fragment_end),
		.run_last      (run_last)
	);

	assign in_stall = q_full;

	`NUFF_ASSERT_IMPL(a_begin_not_end, out_valid && fragment_begin, !fragment_end && !run_last)
	`NUFF_ASSERT_IMPL(a_end_is_last, out_valid && fragment_end, run_last)
	`NUFF_ASSERT_IMPL(a_push_has_room, push, !q_full)
	`NUFF_ASSERT_NEXT(a_pop_frees, pop && q_full, !in_stall)

endmodule

/* hdl/nuff_front.sv */
// ----------------------------------------------------------------------------
// nuff_front
// Accepts NAL bytes, tracks header and fragment state, queues output requests.
// ----------------------------------------------------------------------------
module nuff_front
	import nuff_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        codec_mode,
	input  logic [11:0] max_payload,
	input  logic        in_valid,
	input  logic [7:0]  data_byte,
	input  logic        nal_first,
	input  logic [15:0] nal_length,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job
);

	localparam int EXT_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam int CMP_W = (LENGTH_BITS > FILL_W) ? LENGTH_BITS : FILL_W;

	logic [7:0]             header_first_q;
	logic [7:0]             header_second_q;
	logic [1:0]             hdr_seen_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   first_pend_q;

	logic                   accept;
	logic [1:0]             hlen;
	logic [11:0]            limit;
	logic [EXT_W-1:0]       len_ext;
	logic [LENGTH_BITS-1:0] len;
	logic [LENGTH_BITS-1:0] len_payload;
	logic [LENGTH_BITS-1:0] rem_next;
	logic [FILL_W-1:0]      fill_next;
	logic                   emit;
	logic                   frag_end;
	logic [7:0]             fu_hdr;

	assign accept = in_valid && !q_full;
	assign hlen   = codec_mode ? 2'd2 : 2'd1;
	assign limit  = (max_payload == 12'd0) ? 12'd1 : max_payload;

	assign len_ext     = EXT_W'(nal_length);
	assign len         = len_ext[LENGTH_BITS-1:0];
	assign len_payload = (len > LENGTH_BITS'(hlen)) ? (len - LENGTH_BITS'(hlen))
	                                                : '0;

	assign emit = !nal_first && (hdr_seen_q != 2'd0) && (hdr_seen_q >= hlen)
	              && (rem_q != '0);

	assign rem_next  = rem_q - LENGTH_BITS'(1);
	assign fill_next = fill_q + FILL_W'(1);
	assign frag_end  = (fill_next >= limit) || (rem_next == '0);

	always_comb begin
		fu_hdr = (first_pend_q ? FU_S_BIT : 8'h00)
		       | ((CMP_W'(rem_q) <= CMP_W'(limit)) ? FU_E_BIT : 8'h00);
		push_job.has_hdr  = (fill_q == '0);
		push_job.hevc     = codec_mode;
		push_job.data     = data_byte;
		push_job.frag_end = frag_end;
		if (codec_mode) begin
			push_job.hb0 = (header_first_q & HEVC_KEEP_M) | (HEVC_FU_TYP << 1);
			push_job.hb1 = header_second_q;
			push_job.hb2 = fu_hdr | ((header_first_q & HEVC_TYPE_M) >> 1);
		end else begin
			push_job.hb0 = (header_first_q & H264_KEEP_M) | FU_A_TYPE;
			push_job.hb1 = fu_hdr | (header_first_q & H264_TYPE_M);
			push_job.hb2 = 8'h00;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= 8'h00;
			header_second_q <= 8'h00;
			hdr_seen_q      <= 2'd0;
			rem_q           <= '0;
			fill_q          <= '0;
			first_pend_q    <= 1'b1;
		end else if (accept) begin
			priority if (nal_first) begin
				header_first_q  <= data_byte;
				header_second_q <= 8'h00;
				hdr_seen_q      <= 2'd1;
				rem_q           <= len_payload;
				fill_q          <= '0;
				first_pend_q    <= 1'b1;
			end else if (hdr_seen_q == 2'd0) begin
				// drop: no NAL open
			end else if (hdr_seen_q < hlen) begin
				header_second_q <= data_byte;
				hdr_seen_q      <= 2'd2;
			end else if (emit) begin
				first_pend_q <= 1'b0;
				rem_q        <= rem_next;
				fill_q       <= frag_end ? '0 : fill_next;
			end
		end
	end

endmodule

/* hdl/nuff_queue.sv */
// ----------------------------------------------------------------------------
// nuff_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module nuff_queue
	import nuff_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	job_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

/* hdl/nuff_back.sv */
// ----------------------------------------------------------------------------
// nuff_back
// Emits each payload byte, led by indicator and FU header at fragment start.
// ----------------------------------------------------------------------------
module nuff_back
	import nuff_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       empty,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       fragment_begin,
	output logic       fragment_end,
	output logic       run_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       begin_q;
	logic       end_q;
	logic       last_q;

	logic       load;
	logic [1:0] last_idx;
	logic       is_last;
	logic [7:0] sel_byte;

	assign load     = !out_valid_q || !out_stall;
	assign last_idx = head.has_hdr ? (head.hevc ? 2'd3 : 2'd2) : 2'd0;
	assign is_last  = (idx_q == last_idx);
	assign pop      = load && !empty && is_last;

	always_comb begin
		if (!head.has_hdr) begin
			sel_byte = head.data;
		end else begin
			unique case (idx_q)
				2'd0:    sel_byte = head.hb0;
				2'd1:    sel_byte = head.hb1;
				2'd2:    sel_byte = head.hevc ? head.hb2 : head.data;
				default: sel_byte = head.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			byte_q  <= sel_byte;
			begin_q <= head.has_hdr && (idx_q == 2'd0);
			end_q   <= is_last && head.frag_end;
			last_q  <= is_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = byte_q;
	assign fragment_begin = begin_q;
	assign fragment_end   = end_q;
	assign run_last       = last_q;

endmodule
